### rtl/timed_event_priority_queue_assert.svh
// Assertion macros shared by the timed event priority queue RTL.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define TEPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define TEPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TEPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define TEPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/tepq_pkg.sv
// Package: types, constants and key function of the timed event priority queue.
`default_nettype none

package tepq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int SLOT_W    = 26;
    localparam int KEY_W     = 18;
    localparam int OUT_CNT_W = 5;

    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [7:0] tag;
        logic [5:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_slot;

    function automatic logic [KEY_W-1:0] time_key(input t_slot s);
        time_key = KEY_W'(s.hours) * KEY_W'(SEC_PER_HOUR)
                 + KEY_W'(s.minutes) * KEY_W'(SEC_PER_MIN)
                 + KEY_W'(s.seconds);
    endfunction

endpackage

`default_nettype wire

### rtl/tepq_mem.sv
// Event slot memory: one write port, one registered read port.
`default_nettype none

module tepq_mem
    import tepq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_slot         i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_slot              o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/tepq_scan.sv
// Shared key unit: forms the time key of one slot a cycle and keeps the running minimum.
`default_nettype none

module tepq_scan
    import tepq_pkg::*;
#(
    parameter int AW = $clog2(DEPTH_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic          i_valid,
    input  wire logic [AW-1:0] i_idx,
    input  wire t_slot         i_slot,
    output logic               o_fire,
    output logic [AW-1:0]      o_best_idx,
    output t_slot              o_best_slot
);

    logic             r_k_valid;
    logic [AW-1:0]    r_k_idx;
    t_slot            r_k_slot;
    logic [KEY_W-1:0] r_key;

    logic             r_have;
    logic [KEY_W-1:0] r_best_key;
    logic [AW-1:0]    r_best_idx;
    t_slot            r_best_slot;

    logic w_take;

    // key stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_k_valid <= 1'b0;
        end else begin
            r_k_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_idx  <= i_idx;
        r_k_slot <= i_slot;
        r_key    <= time_key(i_slot);
    end

    // strict less-than keeps the earlier slot on a tie
    assign w_take = r_k_valid && (!r_have || (r_key < r_best_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_have <= 1'b0;
        end else if (w_take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_key  <= r_key;
            r_best_idx  <= r_k_idx;
            r_best_slot <= r_k_slot;
        end
    end

    assign o_fire      = r_k_valid;
    assign o_best_idx  = r_best_idx;
    assign o_best_slot = r_best_slot;

endmodule

`default_nettype wire

### rtl/timed_event_priority_queue.sv
// Top level of the timed event priority queue: sequencer, slot memory and key unit.
//
// Input channel i_valid / o_stall carries one command word: opcode 0 inserts an
// event (tag and h:m:s time), opcode 1 pops the event with the smallest key
// h*3600+m*60+s, the earliest inserted one on a tie. Output channel o_valid /
// i_stall returns one result word per command: status, popped event, count.
// Timing: an insert or an empty pop goes from accept straight to the finish
// step, which loads the result once the output register is free. A pop over n
// held events scans all n slots through the one key unit, one slot a cycle,
// then moves the m slots behind the winner up by one through the memory's
// read and write ports, then loads the result in the finish step. The next
// command can be taken in the same cycle that o_valid rises. One command is
// worked on at a time; o_stall is high from accept until the result is loaded.
// The result sits in an output register; while i_stall holds it, the next
// command is accepted and worked, and its result waits until the register
// frees. Reset empties the table at once; slot contents are not cleared.
`default_nettype none

`include "timed_event_priority_queue_assert.svh"

module timed_event_priority_queue
    import tepq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_client_tag,
    input  wire logic [5:0]  i_event_hours,
    input  wire logic [5:0]  i_event_minutes,
    input  wire logic [5:0]  i_event_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_due_tag,
    output logic [5:0]       o_due_hours,
    output logic [5:0]       o_due_minutes,
    output logic [5:0]       o_due_seconds,
    output logic [OUT_CNT_W-1:0] o_pending_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_op;
    t_slot         r_in;
    logic [CW-1:0] r_rd_idx;
    logic          r_rd_pend;
    logic [AW-1:0] r_rd_addr;
    logic [CW-1:0] r_cmp_cnt;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    t_slot         r_out_slot;
    logic [OUT_CNT_W-1:0] r_out_count;

    logic          w_accept;
    logic          w_issue;
    logic          w_fin;
    logic          w_full;
    logic          w_empty;
    logic [1:0]    w_status;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_slot         w_wdata;
    t_slot         w_rdata;
    logic          w_fire;
    logic [AW-1:0] w_best_idx;
    t_slot         w_best_slot;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == DEPTH_C);
    assign w_empty  = (r_count == '0);
    assign w_issue  = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_count);
    assign w_fin    = (r_state == S_FINISH) && (!r_out_valid || !i_stall);

    always_comb begin
        if (r_op == OP_INSERT) begin
            w_status = w_full ? ST_FULL : ST_INSERTED;
        end else begin
            w_status = w_empty ? ST_EMPTY : ST_POPPED;
        end
    end

    always_comb begin
        unique case (w_status)
            ST_INSERTED: n_count = r_count + CW'(1);
            ST_POPPED:   n_count = r_count - CW'(1);
            default:     n_count = r_count;
        endcase
    end

    // memory write: slot move-up during shift, new event at the tail on insert
    always_comb begin
        if (r_state == S_SHIFT) begin
            w_we    = r_rd_pend;
            w_waddr = r_rd_addr - AW'(1);
            w_wdata = w_rdata;
        end else begin
            w_we    = w_fin && (w_status == ST_INSERTED);
            w_waddr = r_count[AW-1:0];
            w_wdata = r_in;
        end
    end

    tepq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    tepq_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_accept),
        .i_valid     ((r_state == S_SCAN) && r_rd_pend),
        .i_idx       (r_rd_addr),
        .i_slot      (w_rdata),
        .o_fire      (w_fire),
        .o_best_idx  (w_best_idx),
        .o_best_slot (w_best_slot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_pend <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_cnt <= '0;
        end else begin
            r_rd_pend <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rd_idx  <= '0;
                        r_cmp_cnt <= '0;
                        if ((i_opcode == OP_POP) && !w_empty) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_fire) begin
                        r_cmp_cnt <= r_cmp_cnt + CW'(1);
                    end
                    if (r_cmp_cnt == r_count) begin
                        // all slots compared; move up those behind the winner
                        r_rd_idx <= CW'(w_best_idx) + CW'(1);
                        r_state  <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!w_issue && !r_rd_pend) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_fin) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_addr <= r_rd_idx[AW-1:0];
        end
        if (w_accept) begin
            r_op       <= i_opcode;
            r_in.tag     <= i_client_tag;
            r_in.hours   <= i_event_hours;
            r_in.minutes <= i_event_minutes;
            r_in.seconds <= i_event_seconds;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_status <= w_status;
            r_out_slot   <= (w_status == ST_POPPED) ? w_best_slot : '0;
            r_out_count  <= OUT_CNT_W'(n_count);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_due_tag       = r_out_slot.tag;
    assign o_due_hours     = r_out_slot.hours;
    assign o_due_minutes   = r_out_slot.minutes;
    assign o_due_seconds   = r_out_slot.seconds;
    assign o_pending_count = r_out_count;

    `TEPQ_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= DEPTH_C, "event count above depth")
    `TEPQ_ASSERT(a_cmp_bound, i_clk, i_rst_n, (r_state != S_SCAN) || (r_cmp_cnt <= r_count), "more compares than events")
    `TEPQ_ASSERT(a_wr_inside, i_clk, i_rst_n, !w_we || (CW'(w_waddr) < r_count) || (r_state == S_FINISH), "slot move writes past the tail")
    `TEPQ_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, w_fin && (w_status == ST_POPPED), r_count == $past(r_count) - CW'(1), "pop did not remove one event")

endmodule

`default_nettype wire
